### rtl/core/itfl_pkg.sv
package itfl_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = ADDR_W + 1;
   localparam int VALUE_W     = 32;
   localparam int SPAN_W      = ADDR_W;
   localparam int DIV_CNT_W   = $clog2(VALUE_W);
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = ((ADDR_W + VALUE_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TABLE_DEPTH);
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_BP    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd3;

   // item kinds
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // register indexes
   localparam logic REG_TABLE_SIZE = 1'b0;

   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] dividend;
      logic [SPAN_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quot;
      logic [SPAN_W-1:0]  rem;
   } div_rsp_type;

endpackage

### rtl/core/interpolated_table_fill_and_lookup.sv
// channel   | direction | handshake            | payload
// req       | in        | req_tvalid/tready    | tdata: position, value_in; tuser: kind
// rsp       | out       | rsp_tvalid/tready    | tdata: value_out; tuser: status
// csr       | in/out    | apb, pready always 1 | table_size at byte address 0
//
// a lookup passes through accept, a registered table read and the result hand-off.
// a rejected load or a load at position 0 goes from accept straight to the hand-off.
// an interpolating load first runs the serial divider that splits the value
// difference by the span, then makes one table write per entry.
// synchronous reset; the table itself is not cleared, so no sweep follows reset.
// a new item is taken while the previous result waits in the output register;
// the next result then holds until rsp_tready frees that register.
module interpolated_table_fill_and_lookup (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [itfl_pkg::REQ_DATA_W-1:0]      req_tdata,  // position, value_in
   input  logic                                 req_tuser,  // kind
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [itfl_pkg::VALUE_W-1:0]         rsp_tdata,  // value_out
   output logic [itfl_pkg::STATUS_W-1:0]        rsp_tuser,  // status
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [itfl_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [itfl_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [itfl_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import itfl_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_FILL   = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [SIZE_W-1:0]   table_size_ff, table_size_in;
   logic                started_ff, started_in;
   logic                ready_ff, ready_in;
   logic [ADDR_W-1:0]   prev_pos_ff, prev_pos_in;
   logic [VALUE_W-1:0]  prev_value_ff, prev_value_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0]  upper_ff, upper_in;
   logic                up_ff, up_in;
   logic [SPAN_W-1:0]   span_ff, span_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [VALUE_W-1:0]  entry_ff, entry_in;
   logic [SPAN_W-1:0]   frac_ff, frac_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rd_data_ff;

   logic [VALUE_W-1:0]  table_mem [TABLE_DEPTH];

   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [VALUE_W-1:0]  mem_wdata;

   logic                req_fire;
   logic                csr_write;
   logic [SIZE_W-1:0]   used_size;
   logic [ADDR_W-1:0]   req_position;
   logic [VALUE_W-1:0]  req_value;
   logic [SIZE_W-1:0]   req_pos_ext;
   logic                req_up;
   logic [SPAN_W:0]     frac_sum;
   logic                frac_carry;
   logic [VALUE_W-1:0]  step;
   logic [VALUE_W-1:0]  entry_next;
   logic                out_free;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   itfl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_position = req_tdata[ADDR_W-1:0];
   assign req_value    = req_tdata[ADDR_W+VALUE_W-1:ADDR_W];
   assign req_pos_ext  = {1'b0, req_position};
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_TABLE_SIZE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TABLE_SIZE) ?
                       CSR_DATA_W'(table_size_ff) : '0;

   always_comb begin
      if (table_size_ff < SIZE_MIN) begin
         used_size = SIZE_MIN;
      end else if (table_size_ff > SIZE_RESET) begin
         used_size = SIZE_RESET;
      end else begin
         used_size = table_size_ff;
      end
   end

   assign req_up = $signed(req_value) >= $signed(prev_value_ff);

   // running remainder of r*k/span, carries add one to the step
   assign frac_sum   = {1'b0, frac_ff} + {1'b0, div_rsp.rem};
   assign frac_carry = frac_sum >= {1'b0, span_ff};
   assign step       = div_rsp.quot + VALUE_W'(frac_carry);
   assign entry_next = up_ff ? entry_ff + step : entry_ff - step;

   always_comb begin
      state_in      = state_ff;
      table_size_in = table_size_ff;
      started_in    = started_ff;
      ready_in      = ready_ff;
      prev_pos_in   = prev_pos_ff;
      prev_value_in = prev_value_ff;
      pos_in        = pos_ff;
      upper_in      = upper_ff;
      up_in         = up_ff;
      span_in       = span_ff;
      addr_in       = addr_ff;
      entry_in      = entry_ff;
      frac_in       = frac_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = entry_next;
      div_req.start    = 1'b0;
      div_req.dividend = req_up ? req_value - prev_value_ff : prev_value_ff - req_value;
      div_req.divisor  = req_position - prev_pos_ff;

      if (csr_write) begin
         table_size_in = csr_pwdata[SIZE_W-1:0];
         ready_in      = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_value_in  = '0;
               res_status_in = STATUS_OK;
               state_in      = ST_RESULT;
               if (req_tuser == KIND_LOAD) begin
                  if (req_position == '0) begin
                     mem_we        = 1'b1;
                     mem_waddr     = '0;
                     mem_wdata     = req_value;
                     prev_pos_in   = '0;
                     prev_value_in = req_value;
                     started_in    = 1'b1;
                     ready_in      = 1'b0;
                  end else if (!started_ff || req_position <= prev_pos_ff
                               || req_pos_ext >= used_size) begin
                     res_status_in = STATUS_BAD_BP;
                  end else begin
                     div_req.start = 1'b1;
                     pos_in        = req_position;
                     upper_in      = req_value;
                     up_in         = req_up;
                     span_in       = req_position - prev_pos_ff;
                     addr_in       = prev_pos_ff + ADDR_W'(1);
                     entry_in      = prev_value_ff;
                     frac_in       = '0;
                     state_in      = ST_DIV;
                  end
               end else begin
                  if (!ready_ff) begin
                     res_status_in = STATUS_NOT_READY;
                  end else if (req_pos_ext >= used_size) begin
                     res_status_in = STATUS_RANGE;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            mem_we   = 1'b1;
            entry_in = entry_next;
            frac_in  = frac_carry ? SPAN_W'(frac_sum - {1'b0, span_ff})
                                  : frac_sum[SPAN_W-1:0];
            addr_in  = addr_ff + ADDR_W'(1);
            if (addr_ff == pos_ff) begin
               prev_pos_in   = pos_ff;
               prev_value_in = upper_ff;
               if ({1'b0, pos_ff} == used_size - SIZE_W'(1)) begin
                  ready_in = 1'b1;
               end
               state_in = ST_RESULT;
            end
         end
         ST_READ: begin
            res_value_in = rd_data_ff;
            state_in     = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[req_position];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         table_size_ff <= SIZE_RESET;
         started_ff    <= 1'b0;
         ready_ff      <= 1'b0;
         prev_pos_ff   <= '0;
         prev_value_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         table_size_ff <= table_size_in;
         started_ff    <= started_in;
         ready_ff      <= ready_in;
         prev_pos_ff   <= prev_pos_in;
         prev_value_ff <= prev_value_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      upper_ff      <= upper_in;
      up_ff         <= up_in;
      span_ff       <= span_in;
      addr_ff       <= addr_in;
      entry_ff      <= entry_in;
      frac_ff       <= frac_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_ready_needs_start: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> started_ff)
      else $error("table ready without a start breakpoint");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide phase");

   a_fill_frac_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (frac_ff < span_ff && addr_ff <= pos_ff
                                 && addr_ff > prev_pos_ff))
      else $error("fill state out of bounds");

   a_fill_ends_on_upper: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && addr_ff == pos_ff) |-> (entry_next == upper_ff))
      else $error("last filled entry differs from the breakpoint value");

endmodule

### rtl/core/itfl_div.sv
module itfl_div (
   input  logic                 clock,
   input  logic                 reset,
   input  itfl_pkg::div_req_type div_req,
   output itfl_pkg::div_rsp_type div_rsp
);
   import itfl_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VALUE_W-1:0]   work_ff, work_in;
   logic [SPAN_W-1:0]    rem_ff, rem_in;
   logic [SPAN_W-1:0]    divisor_ff, divisor_in;

   logic [SPAN_W:0]      trial;
   logic                 fits;

   // one restoring step per cycle, quotient bits shift in from the right
   assign trial = {rem_ff, work_ff[VALUE_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         work_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[VALUE_W-2:0], fits};
         rem_in  = fits ? SPAN_W'(trial - {1'b0, divisor_ff}) : trial[SPAN_W-1:0];
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = work_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import itfl_pkg::*;

   typedef struct packed {
      logic               kind;
      logic [ADDR_W-1:0]  position;
      logic [VALUE_W-1:0] value;
   } table_op_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } table_reply_type;

   localparam int SPARE_REG        = 1;
   localparam int RANDOM_OPS       = 1700;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_HOLD_EVERY  = 700;
   localparam logic [CSR_ADDR_W-1:0] SIZE_ADDR  = CSR_ADDR_W'(4 * int'(REG_TABLE_SIZE));
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4 * SPARE_REG);
   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   logic                    clock;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata   = '0;  // position, value_in
   logic                    req_tuser   = KIND_LOAD;  // kind
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [VALUE_W-1:0]      rsp_tdata;  // value_out
   logic [STATUS_W-1:0]     rsp_tuser;  // status
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   interpolated_table_fill_and_lookup i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted state of the table
   logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];
   logic [ADDR_W-1:0]  bp_pos        = '0;
   logic [VALUE_W-1:0] bp_value      = '0;
   bit                 load_started  = 1'b0;
   bit                 table_ready   = 1'b0;
   logic [SIZE_W-1:0]  size_reg      = SIZE_RESET;

   table_op_type    pending_ops [$];
   table_reply_type expected_replies [$];
   table_op_type    drive_op;
   table_op_type    seen_op;
   table_reply_type want;
   int           op_total       = 0;
   int           fail_count     = 0;
   int           result_count   = 0;
   bit           req_taken      = 1'b0;
   int           burst_left     = 0;
   int           idle_left      = 0;
   int           hold_left      = 0;
   int           next_long_hold = 150;
   int           ready_pattern  = 0;
   int           pattern_left   = 0;

   function automatic int used_entries(input logic [SIZE_W-1:0] s);
      if (s < SIZE_MIN) return int'(SIZE_MIN);
      if (s > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(s);
   endfunction

   // lower + (upper - lower) * k / span, truncated toward zero
   function automatic logic [VALUE_W-1:0] interp_entry(input logic [VALUE_W-1:0] lower,
                                                      input logic [VALUE_W-1:0] upper,
                                                      input longint k, input longint span);
      longint lo, hi, mag, stride;
      lo = $signed(lower);
      hi = $signed(upper);
      mag = (hi >= lo) ? hi - lo : lo - hi;
      stride = (mag / span) * k + ((mag % span) * k) / span;
      return (hi >= lo) ? VALUE_W'(lo + stride) : VALUE_W'(lo - stride);
   endfunction

   function automatic table_reply_type table_model_step(input table_op_type op);
      table_reply_type r;
      int used, span, k;
      r.value = '0;
      r.status = STATUS_OK;
      used = used_entries(size_reg);
      if (op.kind == KIND_LOAD) begin
         if (op.position == 0) begin
            table_mem[0] = op.value;
            bp_pos = '0;
            bp_value = op.value;
            load_started = 1'b1;
            table_ready = 1'b0;
         end else if (!load_started || op.position <= bp_pos || op.position >= used) begin
            r.status = STATUS_BAD_BP;
         end else begin
            span = int'(op.position) - int'(bp_pos);
            for (k = 1; k <= span; k++) begin
               table_mem[int'(bp_pos) + k] = interp_entry(bp_value, op.value, k, span);
            end
            bp_pos = op.position;
            bp_value = op.value;
            if (op.position == used - 1) table_ready = 1'b1;
         end
      end else begin
         if (!table_ready) r.status = STATUS_NOT_READY;
         else if (op.position >= used) r.status = STATUS_RANGE;
         else r.value = table_mem[op.position];
      end
      return r;
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return VALUE_W'(int'($urandom_range(0, 2000)) - 1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic void push_op(input logic kind, input int pos, input logic [VALUE_W-1:0] value);
      table_op_type op;
      op.kind = kind;
      op.position = ADDR_W'(pos);
      op.value = value;
      pending_ops.push_back(op);
      op_total++;
   endfunction

   function automatic void push_lookups(input int used, input int count);
      repeat (count) begin
         push_op(KIND_LOOKUP, ($urandom_range(0, 5) == 0) ? $urandom_range(0, TABLE_DEPTH - 1)
                                                          : $urandom_range(0, used - 1), $urandom);
      end
   endfunction

   // a position that must be refused: not rising, or past the used size
   function automatic int bad_position(input int cur, input int used);
      if (cur > 0 && (used >= TABLE_DEPTH || $urandom_range(0, 1) == 0))
         return $urandom_range(1, cur);
      if (used < TABLE_DEPTH) return $urandom_range(used, TABLE_DEPTH - 1);
      return -1;
   endfunction

   // breakpoints from 0 rising to used-1; a partial ramp stops short of the end
   function automatic void push_ramp(input int used, input bit finish, input bit noisy);
      int cur, nxt, segs, s, bad;
      segs = $urandom_range(1, (used - 1 < 8) ? used - 1 : 8);
      push_op(KIND_LOAD, 0, rand_value());
      cur = 0;
      for (s = segs; s > (finish ? 0 : 1); s--) begin
         nxt = (s == 1) ? used - 1 : cur + $urandom_range(1, used - 1 - cur - (s - 1));
         if (noisy && $urandom_range(0, 2) == 0) begin
            bad = bad_position(cur, used);
            if (bad > 0) push_op(KIND_LOAD, bad, rand_value());
         end
         push_op(KIND_LOAD, nxt, rand_value());
         cur = nxt;
      end
   endfunction

   task automatic drain();
      @(posedge clock);
      while (pending_ops.size() != 0 || req_tvalid || expected_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_access(input bit write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // sender: bursts of items with random gaps
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (idle_left != 0) begin
            idle_left--;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            drive_op = pending_ops.pop_front();
            req_tdata <= REQ_DATA_W'({drive_op.value, drive_op.position});
            req_tuser <= drive_op.kind;
            req_tvalid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 32);
               idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: changing stall patterns, and a long hold now and then
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (result_count >= next_long_hold) begin
         hold_left = LONG_HOLD_CYCLES;
         next_long_hold += LONG_HOLD_EVERY;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            ready_pattern = $urandom_range(0, 3);
            pattern_left = $urandom_range(8, 80);
         end else begin
            pattern_left--;
         end
         case (ready_pattern)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // monitor: register writes, readback, predicted and actual items
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == SIZE_ADDR) begin
                  size_reg = csr_pwdata[SIZE_W-1:0];
                  table_ready = 1'b0;
               end
            end else if (csr_paddr == SIZE_ADDR && csr_prdata !== CSR_DATA_W'(size_reg)) begin
               $error("table_size: expected %0d, actual %0d", size_reg, csr_prdata);
               fail_count++;
            end
         end
         if (req_tvalid && req_tready) begin
            seen_op.kind = req_tuser;
            seen_op.position = req_tdata[ADDR_W-1:0];
            seen_op.value = req_tdata[ADDR_W +: VALUE_W];
            expected_replies.push_back(table_model_step(seen_op));
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_replies.size() == 0) begin
               $error("unexpected item: value_out %h, status %0d", rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("value_out: expected %h, actual %h", want.value, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      int cur_size, used, size_pick, phase, directed_total;
      logic [CSR_DATA_W-1:0] size_word;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // full-depth table, extreme ramps both ways
      push_op(KIND_LOOKUP, 5, $urandom);
      push_op(KIND_LOAD, 7, rand_value());
      push_op(KIND_LOAD, 0, VALUE_MIN);
      push_op(KIND_LOAD, TABLE_DEPTH - 1, VALUE_MAX);
      push_op(KIND_LOOKUP, 0, $urandom);
      push_op(KIND_LOOKUP, TABLE_DEPTH - 1, $urandom);
      push_op(KIND_LOOKUP, 512, $urandom);
      push_op(KIND_LOAD, TABLE_DEPTH - 1, rand_value());
      push_op(KIND_LOAD, 0, VALUE_MAX);
      push_op(KIND_LOOKUP, 3, $urandom);
      push_op(KIND_LOAD, TABLE_DEPTH - 1, VALUE_MIN);
      push_op(KIND_LOOKUP, 1, $urandom);
      drain();

      // write to a register that does not exist, then size 16 with junk above bit 10
      csr_access(1'b1, SPARE_ADDR, $urandom);
      csr_access(1'b1, SIZE_ADDR, 32'hFFFF_F810);
      csr_access(1'b0, SIZE_ADDR, '0);
      cur_size = 16;
      push_op(KIND_LOOKUP, 2, $urandom);
      push_op(KIND_LOAD, 0, VALUE_W'(1000));
      push_op(KIND_LOAD, 20, rand_value());
      push_op(KIND_LOAD, 9, VALUE_W'(-5000));
      push_op(KIND_LOAD, 5, rand_value());
      push_op(KIND_LOAD, 15, VALUE_W'(32'h0001_8000));
      push_op(KIND_LOOKUP, 15, $urandom);
      push_op(KIND_LOOKUP, 16, $urandom);
      push_op(KIND_LOOKUP, TABLE_DEPTH - 1, $urandom);
      push_op(KIND_LOOKUP, 7, $urandom);
      push_op(KIND_LOAD, 12, rand_value());

      directed_total = op_total;
      phase = 0;
      while (op_total - directed_total < RANDOM_OPS) begin
         phase++;
         drain();
         if ($urandom_range(0, 7) != 0) begin
            case ($urandom_range(0, 15))
               0: size_pick = 0;
               1: size_pick = 1;
               2: size_pick = 2;
               3: size_pick = 2047;
               4: size_pick = TABLE_DEPTH;
               5: size_pick = $urandom_range(100, 1100);
               default: size_pick = $urandom_range(2, 40);
            endcase
            size_word = CSR_DATA_W'(size_pick);
            if ($urandom_range(0, 3) == 0)
               size_word[CSR_DATA_W-1:SIZE_W] = (CSR_DATA_W - SIZE_W)'($urandom);
            csr_access(1'b1, SIZE_ADDR, size_word);
            cur_size = size_pick;
         end
         if ($urandom_range(0, 9) == 0) csr_access(1'b1, SPARE_ADDR, $urandom);
         csr_access(1'b0, SIZE_ADDR, '0);
         used = used_entries(SIZE_W'(cur_size));
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: begin
                  push_ramp(used, 1'b1, $urandom_range(0, 2) == 0);
                  push_lookups(used, $urandom_range(4, 20));
               end
               7: begin
                  push_ramp(used, 1'b0, 1'b1);
                  push_lookups(used, $urandom_range(2, 6));
               end
               8: begin
                  repeat ($urandom_range(3, 10)) begin
                     push_op(($urandom_range(0, 1) == 0) ? KIND_LOAD : KIND_LOOKUP,
                             $urandom_range(0, TABLE_DEPTH - 1), rand_value());
                  end
               end
               default: push_lookups(used, $urandom_range(2, 10));
            endcase
            // one phase where the sender waits for every result between rounds
            if (phase == 8) drain();
         end
      end

      drain();
      repeat (64) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
